// ===== hdl/sine_tone_generator_defines.svh =====
// Assertion macros for the sine tone generator.
`ifndef SINE_TONE_GENERATOR_DEFINES_SVH
`define SINE_TONE_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define STG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sine tone generator check failed");
// Next-cycle implication, disabled while reset is asserted.
`define STG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sine tone generator check failed");
`else
`define STG_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define STG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/stg_pkg.sv =====
// Shared constants, register codes and stage types of the sine tone generator.
`default_nettype none
package stg_pkg;
	localparam int unsigned SINE_TABLE_BITS_DEF = 10;
	localparam int unsigned COUNT_BITS_DEF = 24;

	localparam int unsigned PHASE_W = 32;
	localparam int unsigned AMP_W = 16;
	localparam int unsigned LEN_W = 24;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned ENTRY_W = 15;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PHASE_STEP     = 2'd0,
		CFG_TONE_AMPLITUDE = 2'd1,
		CFG_TONE_LENGTH    = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase_step;
		logic [AMP_W-1:0]   tone_amplitude;
		logic [LEN_W-1:0]   tone_length;
	} cfg_t;

	// Control carried by the first pipeline stage.
	typedef struct packed {
		logic valid;
		logic active;
		logic finished;
		logic negate;
	} stage_ctrl_t;

	// Flow status of the output stage as seen by the first stage.
	typedef struct packed {
		logic take;
		logic space;
	} out_flow_t;
endpackage
`default_nettype wire

// ===== hdl/stg_if.sv =====
// Channel interfaces of the sine tone generator: tick, tone sample and configuration.
`default_nettype none
interface stg_tick_if;
	logic valid;
	logic ready;
	logic restart;
	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface stg_sample_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [stg_pkg::SAMPLE_W-1:0]   sample;
	logic                                  active;
	logic                                  finished;
	modport source (output valid, output sample, output active, output finished, input ready);
	modport sink (input valid, input sample, input active, input finished, output ready);
endinterface

interface stg_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [stg_pkg::CFG_IDX_W-1:0]     index;
	logic [stg_pkg::CFG_DATA_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/sine_tone_generator.sv =====
// Top level of the sine tone generator: direct digital synthesis of a sine tone.
//
//   Channel | Direction | Transaction carries
//   --------+-----------+-------------------------------------------
//   tick    | in        | restart: request one sample, optionally restarting
//   tone    | out       | sample, active, finished
//   cfg     | in        | index, data: write of one configuration register
//
// One tick transaction is taken every clock cycle while the output is not stalled; its
// tone transaction is offered after stage one (phase update and sine table read) and
// the amplitude multiply into the output register.
// Reset clears phase, sample count, configuration and all valid flags; the table is
// a constant and needs no clearing. A stalled output holds its sample while stage
// one still takes a tick, so one tick fits in the pipeline behind a waiting sample.
`default_nettype none
`include "sine_tone_generator_defines.svh"
module sine_tone_generator #(
	parameter int unsigned SINE_TABLE_BITS = stg_pkg::SINE_TABLE_BITS_DEF,
	parameter int unsigned COUNT_BITS = stg_pkg::COUNT_BITS_DEF
) (
	input wire logic        clk,
	input wire logic        arst_n,
	stg_tick_if.sink        tick,
	stg_sample_if.source    tone,
	stg_cfg_if.sink         cfg
);
	stg_pkg::cfg_t          cfg_regs;
	stg_pkg::stage_ctrl_t   ctrl_s1;
	stg_pkg::out_flow_t     flow;
	logic [SINE_TABLE_BITS:0]          rom_addr;
	logic [stg_pkg::ENTRY_W-1:0]       entry_s1;
	logic                              tick_accept;

	// Configuration writes always complete; the user must write only while idle, the block does not enforce it.
	assign cfg.ready = 1'b1;

	stg_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid && cfg.ready),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg_regs (cfg_regs)
	);

	// Stage one is free when empty or when its contents move on this cycle.
	assign tick.ready  = !ctrl_s1.valid || flow.space;
	assign tick_accept = tick.valid && tick.ready;

	stg_phase_ctrl #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.COUNT_BITS      (COUNT_BITS)
	) u_phase_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (tick_accept),
		.restart     (tick.restart),
		.drain       (flow.take),
		.phase_step  (cfg_regs.phase_step),
		.tone_length (cfg_regs.tone_length),
		.rom_addr    (rom_addr),
		.ctrl_s1     (ctrl_s1)
	);

	// The table read shares the stage-one enable so that a stall keeps the entry.
	stg_sine_rom #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_sine_rom (
		.clk      (clk),
		.rd_en    (tick_accept),
		.rd_addr  (rom_addr),
		.entry_s1 (entry_s1)
	);

	stg_scale_out u_scale_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl_s1        (ctrl_s1),
		.entry_s1       (entry_s1),
		.tone_amplitude (cfg_regs.tone_amplitude),
		.out_ready      (tone.ready),
		.out_valid      (tone.valid),
		.out_sample     (tone.sample),
		.out_active     (tone.active),
		.out_finished   (tone.finished),
		.flow           (flow)
	);

	// A silent sample only comes after the tone has run out.
	`STG_ASSERT_SAME(a_silent_is_finished, clk, arst_n, tone.valid && !tone.active, tone.finished && (tone.sample == '0))
	// An accepted tick always occupies stage one in the next cycle.
	`STG_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, tick_accept, ctrl_s1.valid)
	// Stage one keeps its contents while the output stage has no room.
	`STG_ASSERT_NEXT(a_s1_holds_on_stall, clk, arst_n, ctrl_s1.valid && !flow.space, ctrl_s1.valid)
	// A transfer from stage one always presents a sample in the next cycle.
	`STG_ASSERT_NEXT(a_take_shows_sample, clk, arst_n, flow.take, tone.valid)
endmodule
`default_nettype wire

// ===== hdl/stg_cfg_regs.sv =====
// Configuration register file of the sine tone generator.
`default_nettype none
module stg_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [stg_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [stg_pkg::CFG_DATA_W-1:0]  wr_data,
	output stg_pkg::cfg_t                        cfg_regs
);
	stg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				stg_pkg::CFG_PHASE_STEP: begin
					cfg_q.phase_step <= wr_data[stg_pkg::PHASE_W-1:0];
				end
				stg_pkg::CFG_TONE_AMPLITUDE: begin
					cfg_q.tone_amplitude <= wr_data[stg_pkg::AMP_W-1:0];
				end
				stg_pkg::CFG_TONE_LENGTH: begin
					cfg_q.tone_length <= wr_data[stg_pkg::LEN_W-1:0];
				end
				default: begin
					// Unassigned register indexes are dropped.
				end
			endcase
		end
	end

	assign cfg_regs = cfg_q;
endmodule
`default_nettype wire

// ===== hdl/stg_phase_ctrl.sv =====
// Phase accumulator, sample counter and table address for each tick.
`default_nettype none
module stg_phase_ctrl #(
	parameter int unsigned SINE_TABLE_BITS = stg_pkg::SINE_TABLE_BITS_DEF,
	parameter int unsigned COUNT_BITS = stg_pkg::COUNT_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                accept,
	input  wire logic                                restart,
	input  wire logic                                drain,
	input  wire logic [stg_pkg::PHASE_W-1:0]         phase_step,
	input  wire logic [stg_pkg::LEN_W-1:0]           tone_length,
	output logic [SINE_TABLE_BITS:0]                 rom_addr,
	output stg_pkg::stage_ctrl_t                     ctrl_s1
);
	localparam int unsigned LimW = (COUNT_BITS > stg_pkg::LEN_W) ? COUNT_BITS : stg_pkg::LEN_W;
	localparam logic [LimW-1:0] CountMax = LimW'((64'd1 << COUNT_BITS) - 64'd1);
	localparam logic [SINE_TABLE_BITS:0] QuarterSize = (SINE_TABLE_BITS+1)'(1) << SINE_TABLE_BITS;

	logic [stg_pkg::PHASE_W-1:0] phase_q;
	logic [COUNT_BITS-1:0]       count_q;
	logic [stg_pkg::PHASE_W-1:0] phase_eff;
	logic [COUNT_BITS-1:0]       count_eff;
	logic [COUNT_BITS-1:0]       count_inc;
	logic [LimW-1:0]             len_wide;
	logic [LimW-1:0]             limit;
	logic                        active;
	logic                        finished;
	logic [1:0]                  quad;
	logic [SINE_TABLE_BITS-1:0]  idx;

	// Restart clears phase and count before this tick's sample is formed.
	assign phase_eff = restart ? '0 : phase_q;
	assign count_eff = restart ? '0 : count_q;
	assign len_wide  = LimW'(tone_length);
	assign limit     = (len_wide > CountMax) ? CountMax : len_wide;
	assign active    = LimW'(count_eff) < limit;
	assign count_inc = count_eff + COUNT_BITS'(1);
	assign finished  = active ? (LimW'(count_inc) >= limit) : 1'b1;

	assign quad     = phase_eff[stg_pkg::PHASE_W-1 -: 2];
	assign idx      = phase_eff[stg_pkg::PHASE_W-3 -: SINE_TABLE_BITS];
	assign rom_addr = quad[0] ? (QuarterSize - {1'b0, idx}) : {1'b0, idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			count_q <= '0;
			ctrl_s1 <= '0;
		end else begin
			if (accept) begin
				phase_q          <= active ? (phase_eff + phase_step) : phase_eff;
				count_q          <= active ? count_inc : count_eff;
				ctrl_s1.valid    <= 1'b1;
				ctrl_s1.active   <= active;
				ctrl_s1.finished <= finished;
				ctrl_s1.negate   <= quad[1];
			end else if (drain) begin
				ctrl_s1.valid <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/stg_sine_rom.sv =====
// Quarter-wave sine table in unsigned Q0.15, built at elaboration, with a registered read.
`default_nettype none
module stg_sine_rom #(
	parameter int unsigned SINE_TABLE_BITS = stg_pkg::SINE_TABLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          rd_en,
	input  wire logic [SINE_TABLE_BITS:0]      rd_addr,
	output logic [stg_pkg::ENTRY_W-1:0]        entry_s1
);
	localparam int unsigned QuarterSize = 1 << SINE_TABLE_BITS;
	localparam logic [63:0] TaylorQ30 [6] = '{
		64'd1686629713, 64'd693598664, 64'd85569306,
		64'd5026995, 64'd172272, 64'd3864
	};
	localparam logic [63:0] EntryMax = 64'd32767;

	typedef logic [stg_pkg::ENTRY_W-1:0] rom_t [QuarterSize+1];

	// Taylor series of sin(pi/2 * u) in Horner form, Q30 with truncated products.
	function automatic logic [stg_pkg::ENTRY_W-1:0] quarter_entry(input int unsigned i);
		logic [63:0] u;
		logic [63:0] u2;
		logic [63:0] acc;
		logic [63:0] t;
		logic [63:0] e;
		u   = 64'(i) << (30 - SINE_TABLE_BITS);
		u2  = (u * u) >> 30;
		acc = TaylorQ30[5];
		for (int k = 4; k >= 0; k--) begin
			t   = (u2 * acc) >> 30;
			acc = (TaylorQ30[k] > t) ? (TaylorQ30[k] - t) : 64'd0;
		end
		acc = (u * acc) >> 30;
		e   = (acc * EntryMax + 64'd536870912) >> 30;
		if (e > EntryMax) begin
			e = EntryMax;
		end
		return e[stg_pkg::ENTRY_W-1:0];
	endfunction

	function automatic rom_t build_rom();
		rom_t r;
		for (int i = 0; i <= QuarterSize; i++) begin
			r[i] = quarter_entry(i);
		end
		return r;
	endfunction

	localparam rom_t SineRom = build_rom();

	always_ff @(posedge clk) begin
		if (rd_en) begin
			entry_s1 <= SineRom[rd_addr];
		end
	end
endmodule
`default_nettype wire

// ===== hdl/stg_scale_out.sv =====
// Amplitude scaling, sign and saturation, and the output register.
`default_nettype none
module stg_scale_out (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire stg_pkg::stage_ctrl_t                   ctrl_s1,
	input  wire logic [stg_pkg::ENTRY_W-1:0]            entry_s1,
	input  wire logic [stg_pkg::AMP_W-1:0]              tone_amplitude,
	input  wire logic                                   out_ready,
	output logic                                        out_valid,
	output logic signed [stg_pkg::SAMPLE_W-1:0]         out_sample,
	output logic                                        out_active,
	output logic                                        out_finished,
	output stg_pkg::out_flow_t                          flow
);
	localparam int unsigned ProdW = stg_pkg::ENTRY_W + stg_pkg::AMP_W;
	localparam logic [stg_pkg::SAMPLE_W-1:0] PosMax = 16'h7FFF;
	localparam logic [stg_pkg::SAMPLE_W-1:0] NegMag = 16'h8000;

	logic [ProdW-1:0]               prod;
	logic [stg_pkg::SAMPLE_W-1:0]   mag;
	logic [stg_pkg::SAMPLE_W-1:0]   neg_mag;
	logic [stg_pkg::SAMPLE_W-1:0]   sample_d;
	logic                           out_valid_q;
	logic [stg_pkg::SAMPLE_W-1:0]   sample_q;
	logic                           active_q;
	logic                           finished_q;

	// Truncating the magnitude rounds the signed result toward zero.
	assign prod    = {{stg_pkg::AMP_W{1'b0}}, entry_s1}
		* {{stg_pkg::ENTRY_W{1'b0}}, tone_amplitude};
	assign mag     = prod[ProdW-1 -: stg_pkg::SAMPLE_W];
	assign neg_mag = (mag > NegMag) ? NegMag : mag;

	always_comb begin
		if (!ctrl_s1.active) begin
			sample_d = '0;
		end else if (ctrl_s1.negate) begin
			sample_d = '0 - neg_mag;
		end else begin
			sample_d = (mag > PosMax) ? PosMax : mag;
		end
	end

	assign flow.space = !out_valid_q || out_ready;
	assign flow.take  = ctrl_s1.valid && flow.space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (flow.take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (flow.take) begin
			sample_q   <= sample_d;
			active_q   <= ctrl_s1.active;
			finished_q <= ctrl_s1.finished;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_sample   = signed'(sample_q);
	assign out_active   = active_q;
	assign out_finished = finished_q;
endmodule
`default_nettype wire

// ===== bench/sine_tone_checker.sv =====
// Checker for the sine tone generator: predicts every tone transaction and compares it.
module sine_tone_checker (
	input  logic  clk,
	input  logic  arst_n,
	stg_tick_if   tick,
	stg_sample_if tone,
	stg_cfg_if    cfg,
	output int    mismatches,
	output int    outstanding,
	output int    samples_checked,
	output int    tone_samples,
	output int    full_scale_samples
);
	import stg_pkg::*;

	localparam int unsigned TB = SINE_TABLE_BITS_DEF;
	localparam int unsigned QUARTER = 1 << TB;
	localparam logic [TB:0] QUARTER_SLOT = QUARTER;
	localparam logic signed [SAMPLE_W-1:0] PEAK_POS = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] PEAK_NEG = 16'sh8000;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       active;
		logic                       finished;
	} tone_sample_t;

	logic [ENTRY_W-1:0] quarter_sine [0:QUARTER];
	logic [PHASE_W-1:0] phase_step;
	logic [PHASE_W-1:0] phase;
	logic [AMP_W-1:0]   amplitude;
	logic [LEN_W-1:0]   tone_length;
	logic [LEN_W-1:0]   sample_count;
	tone_sample_t       expected_tones [$];

	function automatic longint unsigned taylor_coef(input int k);
		case (k)
			0: return 64'd1686629713;
			1: return 64'd693598664;
			2: return 64'd85569306;
			3: return 64'd5026995;
			4: return 64'd172272;
			default: return 64'd3864;
		endcase
	endfunction

	// Quarter-wave entry in unsigned Q0.15 from a truncated Taylor series of sin(pi/2 * u).
	function automatic logic [ENTRY_W-1:0] sine_entry(input int unsigned i);
		longint unsigned u, u2, acc, t, e;
		u = longint'(i) << (30 - TB);
		u2 = (u * u) >> 30;
		acc = taylor_coef(5);
		for (int k = 4; k >= 0; k--) begin
			t = (u2 * acc) >> 30;
			acc = (taylor_coef(k) > t) ? taylor_coef(k) - t : 64'd0;
		end
		acc = (u * acc) >> 30;
		e = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
		if (e > 64'd32767)
			e = 64'd32767;
		return e[ENTRY_W-1:0];
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] tone_at_phase(input logic [PHASE_W-1:0] ph);
		logic [1:0]    quad;
		logic [TB-1:0] idx;
		logic [TB:0]   slot;
		logic [31:0]   mag;
		logic [15:0]   result;
		quad = ph[31:30];
		idx = ph[29 -: TB];
		slot = quad[0] ? QUARTER_SLOT - {1'b0, idx} : {1'b0, idx};
		mag = ({17'b0, quarter_sine[slot]} * {16'b0, amplitude}) >> 15;
		if (quad[1]) begin
			if (mag > 32'd32768)
				mag = 32'd32768;
			result = 16'd0 - mag[15:0];
		end else begin
			if (mag > 32'd32767)
				mag = 32'd32767;
			result = mag[15:0];
		end
		return result;
	endfunction

	initial begin
		for (int i = 0; i <= QUARTER; i++)
			quarter_sine[i] = sine_entry(i);
	end

	always @(posedge clk) begin
		tone_sample_t want, got;
		if (!arst_n) begin
			phase_step = '0;
			amplitude = '0;
			tone_length = '0;
			phase = '0;
			sample_count = '0;
			expected_tones.delete();
			mismatches <= 0;
			outstanding <= 0;
			samples_checked <= 0;
			tone_samples <= 0;
			full_scale_samples <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg_idx_t'(cfg.index))
					CFG_PHASE_STEP:     phase_step = cfg.data[PHASE_W-1:0];
					CFG_TONE_AMPLITUDE: amplitude = cfg.data[AMP_W-1:0];
					CFG_TONE_LENGTH:    tone_length = cfg.data[LEN_W-1:0];
					default: ;
				endcase
			end
			// The counter is as wide as the length register, so no clamp is needed.
			if (tick.valid && tick.ready) begin
				if (tick.restart) begin
					phase = '0;
					sample_count = '0;
				end
				want = '0;
				if (sample_count < tone_length) begin
					want.sample = tone_at_phase(phase);
					want.active = 1'b1;
					phase = phase + phase_step;
					sample_count = sample_count + 1'b1;
				end
				want.finished = (sample_count >= tone_length);
				expected_tones.insert(expected_tones.size(), want);
			end
			if (tone.valid && tone.ready) begin
				got.sample = tone.sample;
				got.active = tone.active;
				got.finished = tone.finished;
				samples_checked <= samples_checked + 1;
				if (expected_tones.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("Unexpected tone transaction: sample %0d active %0b finished %0b",
							got.sample, got.active, got.finished);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_tones.pop_front();
					if (got !== want) begin
						if (mismatches < REPORT_LIMIT)
							$display("Tone mismatch at %0t: expected %0d/%0b/%0b, got %0d/%0b/%0b",
								$realtime, want.sample, want.active, want.finished,
								got.sample, got.active, got.finished);
						mismatches <= mismatches + 1;
					end
					if (want.active)
						tone_samples <= tone_samples + 1;
					if (want.sample == PEAK_POS || want.sample == PEAK_NEG)
						full_scale_samples <= full_scale_samples + 1;
				end
			end
			outstanding <= expected_tones.size();
		end
	end
endmodule

// ===== bench/sine_tone_generator_test.sv =====
// Top of the sine tone generator test: clock, reset, stimulus, watchdog and verdict.
module sine_tone_generator_test;
	import stg_pkg::*;

	// Index 3 has no register behind it; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
	localparam int QUIET_LIMIT = 4000;
	localparam int RANDOM_TICKS = 750;

	logic clk;
	logic arst_n;

	stg_tick_if   tick_bus ();
	stg_sample_if tone_bus ();
	stg_cfg_if    cfg_bus ();

	int mismatches;
	int outstanding;
	int samples_checked;
	int tone_samples;
	int full_scale_samples;
	int ticks_sent = 0;
	int writes_done = 0;
	int settings_used = 0;
	int quiet_cycles = 0;

	sine_tone_generator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_bus),
		.tone   (tone_bus),
		.cfg    (cfg_bus)
	);

	// The checker sees every transaction on all three channels and predicts the
	// tone stream on its own; this module only makes traffic and decides the verdict.
	sine_tone_checker checker_i (
		.clk                (clk),
		.arst_n             (arst_n),
		.tick               (tick_bus),
		.tone               (tone_bus),
		.cfg                (cfg_bus),
		.mismatches         (mismatches),
		.outstanding        (outstanding),
		.samples_checked    (samples_checked),
		.tone_samples       (tone_samples),
		.full_scale_samples (full_scale_samples)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Idle lengths: mostly back to back or a few cycles, now and then a long pause.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// One tick transaction. Valid stays high when no gap follows, so that the next
	// call only changes the payload and valid never drops and rises in one step.
	task automatic send_tick(input logic restart_bit, input bit steady);
		int unsigned gap;
		tick_bus.valid <= 1'b1;
		tick_bus.restart <= restart_bit;
		do @(posedge clk); while (!tick_bus.ready);
		ticks_sent++;
		gap = steady ? 0 : pick_gap();
		if (gap != 0) begin
			tick_bus.valid <= 1'b0;
			tick_bus.restart <= 1'($urandom_range(0, 1));
			repeat (gap) @(posedge clk);
		end
	endtask

	// One register write; the caller drops valid after the last write of a group.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		writes_done++;
	endtask

	// Writes the registers selected by which, in index order, the unused index last.
	task automatic write_regs(input logic [3:0] which, input logic [31:0] step_d,
		input logic [31:0] amp_d, input logic [31:0] len_d, input logic [31:0] junk_d);
		if (which[0])
			write_reg(CFG_PHASE_STEP, step_d);
		if (which[1])
			write_reg(CFG_TONE_AMPLITUDE, amp_d);
		if (which[2])
			write_reg(CFG_TONE_LENGTH, len_d);
		if (which[3])
			write_reg(CFG_UNUSED_IDX, junk_d);
		cfg_bus.valid <= 1'b0;
		settings_used++;
	endtask

	// Holds the sender back until every predicted sample has been taken. Since the
	// checker updates its count with nonblocking assignments, the value seen here
	// already includes a tick accepted at the previous edge.
	task automatic wait_idle();
		tick_bus.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// The receiver stalls independently of the sender. Roughly a third of the time
	// it stays ready for a long stretch so that full-rate flow is exercised too.
	initial begin
		tone_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			tone_bus.ready <= 1'b1;
			if ($urandom_range(0, 9) < 3)
				repeat ($urandom_range(20, 80)) @(posedge clk);
			else
				repeat ($urandom_range(1, 6)) @(posedge clk);
			tone_bus.ready <= 1'b0;
			repeat (pick_gap() + 1) @(posedge clk);
		end
	end

	// Watchdog: any accepted transaction on any channel counts as progress.
	always @(posedge clk) begin
		if ((tick_bus.valid && tick_bus.ready) || (tone_bus.valid && tone_bus.ready)
			|| (cfg_bus.valid && cfg_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles, %0d samples still due",
				QUIET_LIMIT, outstanding);
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int          random_ticks;
		int          n;
		bit          burst;
		logic        restart_bit;
		logic [3:0]  which;
		logic [31:0] step_d;
		logic [31:0] amp_d;
		logic [31:0] len_d;
		logic [31:0] junk_d;
		logic [31:0] noise;
		logic [15:0] amp_v;
		logic [23:0] len_v;

		random_ticks = 0;
		arst_n = 1'b0;
		tick_bus.valid <= 1'b0;
		tick_bus.restart <= 1'b0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= '0;
		cfg_bus.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A quarter-turn step puts every sample on a quadrant boundary, so the
		// table ends and the sign of each quadrant show up at full scale. The tone
		// runs out after six samples, then a restart brings it back.
		write_regs(4'b0111, 32'h4000_0000, 32'd32768, 32'd6, '0);
		send_tick(1'b1, 1'b1);
		repeat (6) send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b1);
		wait_idle();

		// Amplitude above full scale: the peaks must clip to both 16-bit limits.
		// The upper data bits are set as well and must be dropped.
		write_regs(4'b0110, '0, 32'hFFFF_FFFF, 32'd5, '0);
		send_tick(1'b1, 1'b1);
		repeat (4) send_tick(1'b0, 1'b1);
		wait_idle();

		// Zero length: no tone sample at all, finished from the first tick.
		write_regs(4'b0100, '0, '0, 32'd0, '0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		wait_idle();

		// Largest step wraps the accumulator backward on every sample; the longest
		// length is written with all data bits set. The unused index comes last so
		// that a stray decode of it would corrupt the samples that follow.
		write_regs(4'b1111, 32'hFFFF_FFFF, 32'h0000_8000, 32'hFFFF_FFFF, 32'h1234_5678);
		send_tick(1'b1, 1'b1);
		repeat (4) send_tick(1'b0, 1'b1);
		wait_idle();

		// Random phases. Each one reprograms some or all registers while the block
		// is idle, then sends a run of ticks. Lengths are mostly short so that tones
		// end and restart often; a few are long or the maximum.
		while (random_ticks < RANDOM_TICKS) begin
			which = ($urandom_range(0, 3) != 0) ? 4'b0111 : 4'($urandom_range(1, 15));

			case ($urandom_range(0, 5))
				0: step_d = 32'd0;
				1: step_d = 32'hFFFF_FFFF;
				2: step_d = $urandom_range(1, 1 << 22);
				3: step_d = {2'($urandom_range(0, 3)), 10'($urandom), 20'd0};
				default: step_d = $urandom;
			endcase

			case ($urandom_range(0, 7))
				0: amp_v = 16'd0;
				1: amp_v = 16'd32768;
				2: amp_v = 16'hFFFF;
				3: amp_v = 16'($urandom_range(32769, 65535));
				default: amp_v = 16'($urandom_range(0, 32768));
			endcase
			noise = $urandom;
			amp_d = {noise[31:16], amp_v};

			case ($urandom_range(0, 11))
				0: len_v = 24'd0;
				1: len_v = 24'hFF_FFFF;
				2: len_v = 24'($urandom);
				3: len_v = 24'($urandom_range(1, 2));
				default: len_v = 24'($urandom_range(1, 40));
			endcase
			noise = $urandom;
			len_d = {noise[31:24], len_v};
			junk_d = $urandom;

			wait_idle();
			write_regs(which, step_d, amp_d, len_d, junk_d);

			burst = ($urandom_range(0, 3) == 0);
			n = $urandom_range(8, 48);
			for (int j = 0; j < n; j++) begin
				if (j == 0)
					restart_bit = ($urandom_range(0, 9) < 6);
				else
					restart_bit = ($urandom_range(0, 99) < 8);
				send_tick(restart_bit, burst);
			end
			random_ticks += n;
		end

		wait_idle();
		repeat (8) @(posedge clk);

		$display("Covered %0d ticks and %0d compared samples, %0d inside a tone, %0d at full scale.",
			ticks_sent, samples_checked, tone_samples, full_scale_samples);
		$display("Applied %0d tone settings through %0d register writes.",
			settings_used, writes_done);
		if (mismatches == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
